// File: design/fixed_timestep_frame_pacer_unit_assert.svh
// Assertion macros shared by the pacer RTL.
// FSP_ASSERT_IMP checks a consequent in the same cycle as its antecedent,
// FSP_ASSERT_NXT checks it in the cycle after.
`ifndef FIXED_TIMESTEP_FRAME_PACER_UNIT_ASSERT_SVH
`define FIXED_TIMESTEP_FRAME_PACER_UNIT_ASSERT_SVH

`define FSP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("frame pacer: same-cycle check failed");

`define FSP_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("frame pacer: next-cycle check failed");

`endif

// File: design/fsp_pkg.sv
package fsp_pkg;

    // Field widths
    localparam int DELTA_W   = 24;
    localparam int STEP_W    = 20;
    localparam int ACC_W     = 25;
    localparam int ALPHA_W   = 16;
    localparam int FPS_W     = 24;
    localparam int FRAME_W   = 32;
    localparam int STEPS_W   = 4;
    localparam int CFG_W     = 24;
    localparam int BIT_W     = 5;

    // Stream words
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 104;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (STEPS_W + 1 + ALPHA_W + FPS_W
                                                + DELTA_W + FRAME_W);

    // Register reset values
    localparam logic [STEP_W-1:0]  FIXED_STEP_RESET = 20'd16667;
    localparam logic [DELTA_W-1:0] MAX_FRAME_RESET  = 24'd250000;

    // 1e6 us per second, times 256 for the Q16.8 rate
    localparam logic [27:0] FPS_SCALE = 28'd256000000;

    localparam logic [STEPS_W-1:0] STEPS_OUT_MAX = 4'hF;
    localparam logic [FPS_W-1:0]   FPS_MAX       = 24'hFFFFFF;
    localparam logic [ALPHA_W-1:0] ALPHA_MAX     = 16'hFFFF;

    // Configuration register indexes
    typedef enum logic {
        CFG_FIXED_STEP = 1'b0,
        CFG_MAX_FRAME  = 1'b1
    } t_cfg_index;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_RING,
        S_MUL,
        S_FPS_SAT,
        S_FPS_DIV,
        S_STEP,
        S_ALPHA_SAT,
        S_ALPHA_DIV,
        S_DONE
    } t_state;

endpackage

// File: design/fixed_timestep_frame_pacer_unit.sv
// Fixed-timestep frame pacer.
// Input channel (s_axis): one word per frame, the frame time in us and a pause
// flag. Output channel (m_axis): one word per frame with the fixed-step count,
// the cap flag, the Q0.16 interpolation fraction, the windowed rate in fps*256,
// the clamped frame time and the frame number.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_index
// (0: fixed step length, a zero write is dropped; 1: frame time clamp).
// Per frame the sequencer writes the ring, multiplies the rate numerator,
// runs the rate division (skipped when the window sum is zero or the rate
// saturates), takes the fixed steps, runs the fraction division (skipped
// when it saturates) and loads the output register. All of the step
// counting and both restoring divisions run through one shared subtractor,
// one quotient bit or one step per cycle. s_axis_tready is high only when
// the sequencer is idle, so no frame is taken until the last has left it.
// A finished word sits in the output register, so the next frame may be
// taken while the receiver stalls; a second result waits in the last
// sequencer state until the output register frees.
// Reset (synchronous, active low) restores the register defaults and clears
// the accumulator, window, frame counter and output valid.
`include "fixed_timestep_frame_pacer_unit_assert.svh"

module fixed_timestep_frame_pacer_unit
    import fsp_pkg::*;
#(
    parameter int WINDOW    = 60,
    parameter int MAX_STEPS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // [23:0] frame_delta_us, [24] paused, [31:25] zero
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [3:0] fixed_steps, [4] steps_capped, [20:5] alpha_q16, [44:21] fps_x256,
    // [68:45] clamped_frame_us, [100:69] frame_number, [103:101] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_wdata
);

    localparam int AW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNTW = $clog2(WINDOW + 1);
    localparam int SUMW = DELTA_W + $clog2(WINDOW);
    localparam int UW   = SUMW + 1;
    localparam int NW   = CNTW + 28;
    localparam int SCW  = $clog2(MAX_STEPS + 1);

    // state
    t_state               r_state, n_state;
    logic [STEP_W-1:0]    r_step;
    logic [DELTA_W-1:0]   r_max_frame;
    logic [ACC_W-1:0]     r_acc, n_acc;
    logic [AW-1:0]        r_widx, n_widx;
    logic [CNTW-1:0]      r_count, n_count;
    logic [SUMW-1:0]      r_sum, n_sum;
    logic [FRAME_W-1:0]   r_frame, n_frame;
    logic                 r_ovalid, n_ovalid;

    // per-frame working registers
    logic [DELTA_W-1:0]   r_clamped, n_clamped;
    logic                 r_paused, n_paused;
    logic [NW-1:0]        r_num, n_num;
    logic [DELTA_W-1:0]   r_lo, n_lo;
    logic [UW-1:0]        r_rem, n_rem;
    logic [BIT_W-1:0]     r_bit, n_bit;
    logic [FPS_W-1:0]     r_fps, n_fps;
    logic [ALPHA_W-1:0]   r_alpha, n_alpha;
    logic [SCW-1:0]       r_steps, n_steps;
    logic                 r_capped, n_capped;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    // shared unit and ring
    logic [UW-1:0]        u_a, u_b, u_diff;
    logic                 u_ge;
    logic                 ram_we;
    logic [DELTA_W-1:0]   ram_rdata;

    logic [DELTA_W-1:0]   in_delta;
    logic                 in_paused;
    logic                 in_accept;
    logic                 out_free;
    logic                 steps_left;
    logic [STEPS_W-1:0]   steps_sat;

    assign in_delta   = i_s_axis_tdata[DELTA_W-1:0];
    assign in_paused  = i_s_axis_tdata[DELTA_W];
    assign in_accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free   = !r_ovalid || i_m_axis_tready;
    assign steps_left = r_steps < SCW'(MAX_STEPS);
    assign steps_sat  = (32'(r_steps) > 32'(STEPS_OUT_MAX)) ? STEPS_OUT_MAX
                                                            : STEPS_W'(r_steps);

    fsp_subcmp #(.W(UW)) u_subcmp (
        .i_a    (u_a),
        .i_b    (u_b),
        .o_ge   (u_ge),
        .o_diff (u_diff)
    );

    // ring of clamped samples; read address follows the write index so the
    // entry being replaced is ready in the cycle after accept
    fsp_ram #(.WIDTH(DELTA_W), .DEPTH(WINDOW), .AW(AW)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_widx),
        .i_wdata (r_clamped),
        .i_raddr (r_widx),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_RING;
                end
            end
            S_RING:    n_state = S_MUL;
            S_MUL:     n_state = S_FPS_SAT;
            S_FPS_SAT: begin
                if ((r_sum == '0) || u_ge) begin
                    n_state = S_STEP;
                end else begin
                    n_state = S_FPS_DIV;
                end
            end
            S_FPS_DIV: begin
                if (r_bit == '0) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (r_paused || !(u_ge && steps_left)) begin
                    n_state = S_ALPHA_SAT;
                end
            end
            S_ALPHA_SAT: begin
                if (u_ge) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_ALPHA_DIV;
                end
            end
            S_ALPHA_DIV: begin
                if (r_bit == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer: handshake, ring write and shared-unit operands
    always_comb begin
        o_s_axis_tready = 1'b0;
        ram_we          = 1'b0;
        u_a             = '0;
        u_b             = '0;
        case (r_state)
            S_IDLE:      o_s_axis_tready = 1'b1;
            S_RING:      ram_we = 1'b1;
            S_FPS_SAT: begin
                u_a = UW'(r_num[NW-1:DELTA_W]);
                u_b = UW'(r_sum);
            end
            S_FPS_DIV: begin
                u_a = {r_rem[UW-2:0], r_lo[DELTA_W-1]};
                u_b = UW'(r_sum);
            end
            S_STEP, S_ALPHA_SAT: begin
                u_a = UW'(r_acc);
                u_b = UW'(r_step);
            end
            S_ALPHA_DIV: begin
                u_a = {r_rem[UW-2:0], 1'b0};
                u_b = UW'(r_step);
            end
            default: begin
                o_s_axis_tready = 1'b0;
            end
        endcase
    end

    // datapath updates
    always_comb begin
        n_acc      = r_acc;
        n_widx     = r_widx;
        n_count    = r_count;
        n_sum      = r_sum;
        n_frame    = r_frame;
        n_ovalid   = r_ovalid;
        n_clamped  = r_clamped;
        n_paused   = r_paused;
        n_num      = r_num;
        n_lo       = r_lo;
        n_rem      = r_rem;
        n_bit      = r_bit;
        n_fps      = r_fps;
        n_alpha    = r_alpha;
        n_steps    = r_steps;
        n_capped   = r_capped;
        n_out_data = r_out_data;

        // output register drains independently of the sequencer
        if (r_ovalid && i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_clamped = (in_delta > r_max_frame) ? r_max_frame : in_delta;
                    n_paused  = in_paused;
                    n_steps   = '0;
                    n_capped  = 1'b0;
                end
            end
            // push into the window, accumulate, count the frame
            S_RING: begin
                if (r_count >= CNTW'(WINDOW)) begin
                    n_sum = r_sum - SUMW'(ram_rdata) + SUMW'(r_clamped);
                end else begin
                    n_count = r_count + CNTW'(1);
                    n_sum   = r_sum + SUMW'(r_clamped);
                end
                n_widx  = (r_widx == AW'(WINDOW - 1)) ? '0 : r_widx + AW'(1);
                n_frame = r_frame + FRAME_W'(1);
                if (!r_paused) begin
                    n_acc = r_acc + ACC_W'(r_clamped);
                end
            end
            S_MUL: begin
                n_num = NW'(r_count) * NW'(FPS_SCALE);
            end
            // quotient of 2^24 or more saturates
            S_FPS_SAT: begin
                if (r_sum == '0) begin
                    n_fps = '0;
                end else if (u_ge) begin
                    n_fps = FPS_MAX;
                end else begin
                    n_rem = UW'(r_num[NW-1:DELTA_W]);
                    n_lo  = r_num[DELTA_W-1:0];
                    n_bit = BIT_W'(FPS_W - 1);
                    n_fps = '0;
                end
            end
            S_FPS_DIV: begin
                n_rem = u_ge ? u_diff : u_a;
                n_lo  = {r_lo[DELTA_W-2:0], 1'b0};
                n_fps = {r_fps[FPS_W-2:0], u_ge};
                n_bit = r_bit - BIT_W'(1);
            end
            // take whole steps one per cycle, clear on cap; nothing while paused
            S_STEP: begin
                if (!r_paused) begin
                    if (u_ge && steps_left) begin
                        n_acc   = ACC_W'(u_diff);
                        n_steps = r_steps + SCW'(1);
                    end else if (!steps_left) begin
                        n_acc    = '0;
                        n_capped = 1'b1;
                    end
                end
            end
            S_ALPHA_SAT: begin
                if (u_ge) begin
                    n_alpha = ALPHA_MAX;
                end else begin
                    n_rem   = UW'(r_acc);
                    n_bit   = BIT_W'(ALPHA_W - 1);
                    n_alpha = '0;
                end
            end
            S_ALPHA_DIV: begin
                n_rem   = u_ge ? u_diff : u_a;
                n_alpha = {r_alpha[ALPHA_W-2:0], u_ge};
                n_bit   = r_bit - BIT_W'(1);
            end
            S_DONE: begin
                if (out_free) begin
                    n_ovalid   = 1'b1;
                    n_out_data = {{OUT_PAD_W{1'b0}}, r_frame, r_clamped, r_fps,
                                  r_alpha, r_capped, steps_sat};
                end
            end
            default: begin
                n_ovalid = r_ovalid;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= FIXED_STEP_RESET;
            r_max_frame <= MAX_FRAME_RESET;
            r_acc       <= '0;
            r_widx      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_frame     <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_acc    <= n_acc;
            r_widx   <= n_widx;
            r_count  <= n_count;
            r_sum    <= n_sum;
            r_frame  <= n_frame;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FIXED_STEP: begin
                        if (i_cfg_wdata[STEP_W-1:0] != '0) begin
                            r_step <= i_cfg_wdata[STEP_W-1:0];
                        end
                    end
                    CFG_MAX_FRAME: r_max_frame <= i_cfg_wdata[DELTA_W-1:0];
                    default:       r_max_frame <= r_max_frame;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_clamped  <= n_clamped;
        r_paused   <= n_paused;
        r_num      <= n_num;
        r_lo       <= n_lo;
        r_rem      <= n_rem;
        r_bit      <= n_bit;
        r_fps      <= n_fps;
        r_alpha    <= n_alpha;
        r_steps    <= n_steps;
        r_capped   <= n_capped;
        r_out_data <= n_out_data;
    end

    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tvalid = r_ovalid;

    // checks
    `FSP_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNTW'(WINDOW))
    `FSP_ASSERT_IMP(a_widx_bound, i_clk, i_rst_n, 1'b1, r_widx <= AW'(WINDOW - 1))
    `FSP_ASSERT_IMP(a_steps_bound, i_clk, i_rst_n, r_state == S_ALPHA_SAT,
                    r_steps <= SCW'(MAX_STEPS))
    `FSP_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, in_accept, r_state == S_RING)
    `FSP_ASSERT_NXT(a_done_loads, i_clk, i_rst_n, (r_state == S_DONE) && out_free,
                    o_m_axis_tvalid && (r_state == S_IDLE))

endmodule

// File: design/fsp_ram.sv
module fsp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 60,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/fsp_subcmp.sv
module fsp_subcmp #(
    parameter int W = 31
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic         o_ge,
    output logic [W-1:0] o_diff
);

    logic [W:0] sub;

    // a - b with the borrow kept; no borrow means a >= b
    assign sub    = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge   = ~sub[W];
    assign o_diff = sub[W-1:0];

endmodule

// File: tb/sv/fsp_pacer_checker.sv
`timescale 1ns / 1ps

// Watches the frame pacer's stream channels and register port, predicts every
// output word from its own copy of the pacer state and compares field by field.
module fsp_pacer_checker
    import fsp_pkg::*;
#(
    parameter int WINDOW    = 60,
    parameter int MAX_STEPS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // [23:0] frame_delta_us, [24] paused, [31:25] zero
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    // [3:0] fixed_steps, [4] steps_capped, [20:5] alpha_q16, [44:21] fps_x256,
    // [68:45] clamped_frame_us, [100:69] frame_number, [103:101] zero
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    output int                     o_mismatches,
    output int                     o_words_due
);

    // Output word; the last member sits in the lowest bits
    typedef struct packed {
        logic [OUT_PAD_W-1:0] pad;
        logic [FRAME_W-1:0]   frame_number;
        logic [DELTA_W-1:0]   clamped_us;
        logic [FPS_W-1:0]     fps_x256;
        logic [ALPHA_W-1:0]   alpha_q16;
        logic                 steps_capped;
        logic [STEPS_W-1:0]   fixed_steps;
    } t_pacer_word;

    // Predicted pacer state
    logic [STEP_W-1:0]  step_len_us;
    logic [DELTA_W-1:0] clamp_us;
    logic [31:0]        owed_us;
    logic [DELTA_W-1:0] frame_ring [WINDOW];
    int unsigned        ring_wr;
    int unsigned        ring_fill;
    logic [63:0]        ring_sum_us;
    logic [FRAME_W-1:0] frames_seen;

    t_pacer_word        words_due [$];
    int                 mismatches = 0;

    // Advance the predicted state by one frame and build its output word
    function automatic t_pacer_word pace_frame(input logic [DELTA_W-1:0] delta_us,
                                               input logic paused);
        t_pacer_word        w;
        logic [DELTA_W-1:0] clamped;
        logic [63:0]        rate;
        logic [63:0]        frac;
        int unsigned        steps;
        w = '0;
        steps = 0;
        clamped = (delta_us > clamp_us) ? clamp_us : delta_us;

        // sliding window of clamped frame times
        if (ring_fill >= WINDOW) begin
            ring_sum_us = ring_sum_us - 64'(frame_ring[ring_wr]);
        end else begin
            ring_fill++;
        end
        frame_ring[ring_wr] = clamped;
        ring_sum_us = ring_sum_us + 64'(clamped);
        ring_wr = (ring_wr == WINDOW - 1) ? 0 : ring_wr + 1;
        if (ring_sum_us == 0) begin
            rate = 0;
        end else begin
            rate = (64'(ring_fill) * 64'(FPS_SCALE)) / ring_sum_us;
        end
        if (rate > 64'(FPS_MAX)) rate = 64'(FPS_MAX);

        // fixed steps, cleared on reaching the cap
        if (!paused) begin
            owed_us = owed_us + 32'(clamped);
            while (owed_us >= 32'(step_len_us) && steps < MAX_STEPS) begin
                owed_us = owed_us - 32'(step_len_us);
                steps++;
            end
            if (steps >= MAX_STEPS) begin
                owed_us = 0;
                w.steps_capped = 1'b1;
            end
        end

        frac = (64'(owed_us) << 16) / 64'(step_len_us);
        if (frac > 64'(ALPHA_MAX)) frac = 64'(ALPHA_MAX);

        frames_seen = frames_seen + 1'b1;

        w.fixed_steps  = (steps > 15) ? STEPS_OUT_MAX : steps[STEPS_W-1:0];
        w.alpha_q16    = frac[ALPHA_W-1:0];
        w.fps_x256     = rate[FPS_W-1:0];
        w.clamped_us   = clamped;
        w.frame_number = frames_seen;
        return w;
    endfunction

    task automatic flag(input string msg);
        if (mismatches < 10) $display("frame pacer mismatch: %s", msg);
        mismatches++;
    endtask

    task automatic note_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
        if (got !== want) begin
            flag($sformatf("%s expected %0d, got %0d", name, want, got));
        end
    endtask

    // Register writes, accepted frames and returned words, one edge at a time
    always @(posedge i_clk) begin : watch
        t_pacer_word got;
        t_pacer_word want;
        if (!i_rst_n) begin
            step_len_us = FIXED_STEP_RESET;
            clamp_us    = MAX_FRAME_RESET;
            owed_us     = 0;
            ring_wr     = 0;
            ring_fill   = 0;
            ring_sum_us = 0;
            frames_seen = '0;
            words_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_FIXED_STEP) begin
                    // a zero step length is dropped
                    if (i_cfg_wdata[STEP_W-1:0] != '0) step_len_us = i_cfg_wdata[STEP_W-1:0];
                end else begin
                    clamp_us = i_cfg_wdata[DELTA_W-1:0];
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                words_due.push_back(pace_frame(i_s_tdata[DELTA_W-1:0], i_s_tdata[DELTA_W]));
            end
            if (i_m_tvalid && i_m_tready) begin
                got = t_pacer_word'(i_m_tdata);
                if (words_due.size() == 0) begin
                    flag($sformatf("word %h with nothing expected", i_m_tdata));
                end else begin
                    want = words_due.pop_front();
                    note_field("fixed_steps", 64'(want.fixed_steps), 64'(got.fixed_steps));
                    note_field("steps_capped", 64'(want.steps_capped), 64'(got.steps_capped));
                    note_field("alpha_q16", 64'(want.alpha_q16), 64'(got.alpha_q16));
                    note_field("fps_x256", 64'(want.fps_x256), 64'(got.fps_x256));
                    note_field("clamped_frame_us", 64'(want.clamped_us), 64'(got.clamped_us));
                    note_field("frame_number", 64'(want.frame_number), 64'(got.frame_number));
                    note_field("padding", 64'(want.pad), 64'(got.pad));
                end
            end
        end
        o_mismatches <= mismatches;
        o_words_due  <= words_due.size();
    end

endmodule

// File: tb/sv/tb_fixed_timestep_frame_pacer_unit.sv
`timescale 1ns / 1ps

module tb_fixed_timestep_frame_pacer_unit;
    import fsp_pkg::*;

    localparam int WINDOW        = 60;
    localparam int MAX_STEPS     = 10;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    // [23:0] frame_delta_us, [24] paused, [31:25] zero
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // [3:0] fixed_steps, [4] steps_capped, [20:5] alpha_q16, [44:21] fps_x256,
    // [68:45] clamped_frame_us, [100:69] frame_number, [103:101] zero
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic                   cfg_we    = 1'b0;
    t_cfg_index             cfg_index = CFG_FIXED_STEP;
    logic [CFG_W-1:0]       cfg_wdata = '0;

    int                     mismatches;
    int                     words_due;
    logic                   calm       = 1'b0;
    int                     hold_reqs  = 0;
    int                     holds_done = 0;
    logic [STEP_W-1:0]      cur_step   = FIXED_STEP_RESET;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    fixed_timestep_frame_pacer_unit #(
        .WINDOW    (WINDOW),
        .MAX_STEPS (MAX_STEPS)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata)
    );

    fsp_pacer_checker #(
        .WINDOW    (WINDOW),
        .MAX_STEPS (MAX_STEPS)
    ) u_watch (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tdata    (s_tdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .o_mismatches (mismatches),
        .o_words_due  (words_due)
    );

    // Offer one frame word, after an optional gap, and wait for its acceptance
    task automatic send_frame(input logic [DELTA_W-1:0] delta_us, input logic paused);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tdata  <= {{(IN_TDATA_W - DELTA_W - 1){1'b0}}, paused, delta_us};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Stop offering and wait for every outstanding word to come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (words_due != 0) @(posedge clk);
    endtask

    // Both registers, written back to back while the block is idle
    task automatic set_config(input logic [STEP_W-1:0] step_us,
                              input logic [DELTA_W-1:0] clamp_us);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FIXED_STEP;
        cfg_wdata <= CFG_W'(step_us);
        @(posedge clk);
        cfg_index <= CFG_MAX_FRAME;
        cfg_wdata <= clamp_us;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (step_us != '0) cur_step = step_us;
    endtask

    // Receiving side: random stalls, long hold-offs on request, none when calm
    initial begin : drain_side
        forever begin
            if (hold_reqs != holds_done) begin
                // long stall so the block backs up and refuses input
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end else begin
                m_tready <= 1'b1;
                repeat (calm ? 1 : $urandom_range(1, 40)) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        logic [STEP_W-1:0]  step_us;
        logic [DELTA_W-1:0] clamp_us;
        logic [31:0]        d;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: empty window, rate saturation, cap, exact step
        send_frame(24'd0, 1'b0);
        send_frame(24'd0, 1'b1);
        send_frame(24'd1, 1'b0);
        send_frame(24'hFFFFFF, 1'b0);
        send_frame(24'd16667, 1'b0);
        send_frame(24'd16666, 1'b0);
        send_frame(24'hFFFFFF, 1'b1);
        drain();

        // shortest step, no clamp: step count just below, at and past the cap
        set_config(20'd1, 24'hFFFFFF);
        send_frame(24'hFFFFFF, 1'b0);
        send_frame(24'd9, 1'b0);
        send_frame(24'd10, 1'b0);
        send_frame(24'd11, 1'b0);
        send_frame(24'd1, 1'b1);
        drain();

        // widest step, 1 us clamp
        set_config(20'hFFFFF, 24'd1);
        send_frame(24'd5, 1'b0);
        send_frame(24'd0, 1'b0);
        drain();

        // zero step write is dropped; build up a large accumulator
        set_config(20'd0, 24'd1000000);
        send_frame(24'd999999, 1'b0);
        drain();

        // step shortened under a held accumulator: fraction saturates
        set_config(20'd1, 24'd1000000);
        send_frame(24'd5, 1'b1);
        send_frame(24'd0, 1'b0);
        drain();

        // random phases, each with its own settings
        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 0) begin
                step_us  = 20'd1000000;
                clamp_us = 24'hFFFFFF;
            end else if (ph == 1) begin
                // zero clamp long enough to empty the window sum
                step_us  = 20'hFFFFF;
                clamp_us = 24'd0;
            end else if (ph == 9) begin
                step_us  = FIXED_STEP_RESET;
                clamp_us = MAX_FRAME_RESET;
            end else begin
                case ($urandom_range(0, 5))
                    0:       step_us = FIXED_STEP_RESET;
                    1:       step_us = STEP_W'($urandom_range(1, 64));
                    2:       step_us = 20'hFFFFF;
                    3:       step_us = 20'd1;
                    4:       step_us = 20'd0;
                    default: step_us = STEP_W'($urandom_range(1, 20'hFFFFF));
                endcase
                case ($urandom_range(0, 5))
                    0:       clamp_us = MAX_FRAME_RESET;
                    1:       clamp_us = 24'd0;
                    2:       clamp_us = 24'd1;
                    3:       clamp_us = 24'hFFFFFF;
                    4:       clamp_us = DELTA_W'($urandom_range(1, 5000));
                    default: clamp_us = DELTA_W'($urandom());
                endcase
            end
            set_config(step_us, clamp_us);
            if (ph == 9) calm <= 1'b1;

            for (int k = 0; k < 110; k++) begin
                if ((ph == 3 || ph == 6) && k == 20) hold_reqs <= hold_reqs + 1;
                // frame times: whole steps, near misses, tiny, huge
                case ($urandom_range(0, 7))
                    0:       d = $urandom() & 32'hFFFFFF;
                    1:       d = 0;
                    2:       d = $urandom_range(0, 64);
                    3, 4:    d = cur_step * $urandom_range(0, 12) + $urandom_range(0, 2) - 1;
                    5:       d = $urandom_range(0, 40000);
                    6:       d = 32'hFFFFFF;
                    default: d = $urandom_range(0, 2 * cur_step);
                endcase
                if (d > 32'hFFFFFF) d = 32'hFFFFFF;
                send_frame(d[DELTA_W-1:0], $urandom_range(0, 4) == 0);
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && words_due == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
